// ===== hw/rtl/timer_pool_countdown_bank_defines.svh =====
// Assertion macros for the timer pool RTL.
// Included by the top level; relies on nothing else.
`ifndef TIMER_POOL_COUNTDOWN_BANK_DEFINES_SVH
`define TIMER_POOL_COUNTDOWN_BANK_DEFINES_SVH

// Condition c must hold in the same cycle as a, outside reset.
`define TPCB_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("timer pool: same-cycle check failed");

// Condition c must hold in the cycle after a, outside reset.
`define TPCB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("timer pool: next-cycle check failed");

`endif

// ===== hw/rtl/tpcb_pkg.sv =====
// Shared types and codes of the timer pool countdown bank.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tpcb_pkg;

    // Default number of timer slots.
    localparam int TIMER_COUNT_DEFAULT = 8;

    // Operation codes of a request.
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_FREE    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_SERVICE = 3'd5;

    // Status codes of a response.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the request payload
        logic apply;     // decode and apply single-slot operations
        logic scan;      // examine one slot of an allocate or service scan
        logic issue;     // issue one slot of the tick sweep
        logic load_out;  // move the finished result to the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;        // operation held for the request in flight
        logic       hit;       // scanned slot matches
        logic       idx_last;  // slot counter stands at the last slot
        logic       out_free;  // output register can take a result
    } dp_stat_t;

endpackage

// ===== hw/rtl/tpcb_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the timer pool.
// Depends on nothing else.
`timescale 1ns / 1ps

interface tpcb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [2:0]  slot;
    logic [31:0] period;
    logic        one_shot;

    modport source (output valid, output op, output slot, output period,
                    output one_shot, input ready);
    modport sink   (input valid, input op, input slot, input period,
                    input one_shot, output ready);
endinterface

interface tpcb_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] result_slot;
    logic       fire_one_shot;
    logic       wake;

    modport source (output valid, output status, output result_slot,
                    output fire_one_shot, output wake, input ready);
    modport sink   (input valid, input status, input result_slot,
                    input fire_one_shot, input wake, output ready);
endinterface

// ===== hw/rtl/timer_pool_countdown_bank.sv =====
// Top level of the timer pool countdown bank: controller plus datapath.
// Depends on tpcb_pkg, the channel interfaces and the assertion macro header.
//
//   Channel | Direction | Carries
//   --------+-----------+-------------------------------------------
//   req     | in        | op, slot, period, one_shot
//   rsp     | out       | status, result_slot, fire_one_shot, wake
//
// Start, stop, free and unknown operations pass through decode and finish.
// Allocate and service scan the slots in order up to the first match or the
// last slot; tick sweeps all TIMER_COUNT slots, one slot per cycle through the
// single read port of the count memories, then drains the last write-back.
// Reset clears all slot flags; the count memories are written by start before use.
// A new request is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "timer_pool_countdown_bank_defines.svh"

module timer_pool_countdown_bank #(
    parameter int TIMER_COUNT = tpcb_pkg::TIMER_COUNT_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    tpcb_req_if.sink    req,
    tpcb_rsp_if.source  rsp
);

    tpcb_pkg::ctrl_cmd_t cmd;
    tpcb_pkg::dp_stat_t  stat;
    logic                req_ready;
    logic                wake_rsp_ok;

    // Sequencing.
    tpcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Timer state and result path.
    tpcb_datapath #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_op            (req.op),
        .req_slot          (req.slot),
        .req_period        (req.period),
        .req_one_shot      (req.one_shot),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_status        (rsp.status),
        .rsp_result_slot   (rsp.result_slot),
        .rsp_fire_one_shot (rsp.fire_one_shot),
        .rsp_wake          (rsp.wake)
    );

    assign req.ready = req_ready;

    // A wake flag only ever comes with a plain successful tick response.
    assign wake_rsp_ok = (rsp.status == tpcb_pkg::ST_OK) && !rsp.fire_one_shot;

    // Checks.
    `TPCB_ASSERT_NEXT(a_one_request_at_a_time, clk, rst_n, req.valid && req_ready, !req_ready)
    `TPCB_ASSERT_SAME(a_load_only_when_free, clk, rst_n, cmd.load_out, stat.out_free)
    `TPCB_ASSERT_SAME(a_wake_only_on_ok, clk, rst_n, rsp.valid && rsp.wake, wake_rsp_ok)

endmodule

// ===== hw/rtl/tpcb_ctrl.sv =====
// Controller state machine of the timer pool: sequences decode, scans and sweeps.
// Depends on tpcb_pkg for the command and status structs and the operation codes.
`timescale 1ns / 1ps

module tpcb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tpcb_pkg::dp_stat_t  stat,
    output tpcb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.apply = 1'b1;
                if ((stat.op == tpcb_pkg::OP_ALLOC) || (stat.op == tpcb_pkg::OP_SERVICE))
                begin
                    state_next = S_SCAN;
                end
                else if (stat.op == tpcb_pkg::OP_TICK)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.idx_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last slot of the sweep is written back in this cycle.
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tpcb_datapath.sv =====
// Datapath of the timer pool: slot flags, count memories, sweep stage and result registers.
// Depends on tpcb_pkg for the command and status structs and the operation and status codes.
`timescale 1ns / 1ps

module tpcb_datapath #(
    parameter int TIMER_COUNT = tpcb_pkg::TIMER_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tpcb_pkg::ctrl_cmd_t cmd,
    output tpcb_pkg::dp_stat_t  stat,
    input  logic [2:0]          req_op,
    input  logic [2:0]          req_slot,
    input  logic [31:0]         req_period,
    input  logic                req_one_shot,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          rsp_status,
    output logic [2:0]          rsp_result_slot,
    output logic                rsp_fire_one_shot,
    output logic                rsp_wake
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

    // Request held for the operation in flight.
    logic [2:0]  op_reg;
    logic [2:0]  slot_reg;
    logic [31:0] period_reg;
    logic        one_shot_reg;

    // Per-slot flags.
    logic [TIMER_COUNT-1:0] in_use_reg,  in_use_next;
    logic [TIMER_COUNT-1:0] running_reg, running_next;
    logic [TIMER_COUNT-1:0] expired_reg, expired_next;
    logic [TIMER_COUNT-1:0] mode_reg,    mode_next;

    // Slot counter shared by scans and sweeps.
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Sweep stage: read data and slot of the entry being counted down.
    logic             s1_vld_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [31:0]      rem_rd_reg;
    logic [31:0]      rel_rd_reg;

    // Count memories. Read data is used only for a running slot, and every start
    // writes both entries first, so neither memory needs clearing.
    logic [31:0] rem_mem [TIMER_COUNT];
    logic [31:0] rel_mem [TIMER_COUNT];

    // Finished result and output register.
    logic [1:0] res_status_reg, res_status_next;
    logic [2:0] res_slot_reg,   res_slot_next;
    logic       res_fire_reg,   res_fire_next;
    logic       res_wake_reg,   res_wake_next;
    logic       out_valid_reg,  out_valid_next;
    logic [1:0] out_status_reg;
    logic [2:0] out_slot_reg;
    logic       out_fire_reg;
    logic       out_wake_reg;

    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic             start_ok;
    logic             stop_ok;
    logic             hit;
    logic             s1_active;
    logic [31:0]      s1_rem_dec;
    logic             s1_expire;
    logic [31:0]      s1_rem_new;
    logic             rem_we;
    logic [IDX_W-1:0] rem_wa;
    logic [31:0]      rem_wd;

    // Slot checks for the single-slot operations.
    assign slot_ok  = {5'd0, slot_reg} < 8'(TIMER_COUNT);
    assign slot_idx = IDX_W'(slot_reg);
    assign start_ok = cmd.apply && (op_reg == tpcb_pkg::OP_START) && slot_ok
                      && in_use_reg[slot_idx] && (period_reg != 32'd0);
    assign stop_ok  = slot_ok && in_use_reg[slot_idx];

    // Match of the slot under the scan counter.
    assign hit = (op_reg == tpcb_pkg::OP_ALLOC) ? !in_use_reg[idx_reg]
                                                : (in_use_reg[idx_reg] && expired_reg[idx_reg]);

    // Countdown of the swept slot.
    assign s1_active  = s1_vld_reg && in_use_reg[s1_idx_reg] && running_reg[s1_idx_reg];
    assign s1_rem_dec = (rem_rd_reg != 32'd0) ? (rem_rd_reg - 32'd1) : 32'd0;
    assign s1_expire  = (s1_rem_dec == 32'd0);
    assign s1_rem_new = (s1_expire && !mode_reg[s1_idx_reg]) ? rel_rd_reg : s1_rem_dec;

    // Write port of the remaining-count memory.
    assign rem_we = start_ok || s1_active;
    assign rem_wa = start_ok ? slot_idx : s1_idx_reg;
    assign rem_wd = start_ok ? period_reg : s1_rem_new;

    assign stat.op       = op_reg;
    assign stat.hit      = hit;
    assign stat.idx_last = (idx_reg == LAST_IDX);
    assign stat.out_free = !out_valid_reg || rsp_ready;

    // Next values of flags, slot counter and result.
    always_comb
    begin
        in_use_next     = in_use_reg;
        running_next    = running_reg;
        expired_next    = expired_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_fire_next   = res_fire_reg;
        res_wake_next   = res_wake_reg;

        if (cmd.apply)
        begin
            idx_next        = '0;
            res_status_next = tpcb_pkg::ST_OK;
            res_slot_next   = 3'd0;
            res_fire_next   = 1'b0;
            res_wake_next   = 1'b0;
            case (op_reg)
                tpcb_pkg::OP_START:
                begin
                    if (start_ok)
                    begin
                        mode_next[slot_idx]    = one_shot_reg;
                        expired_next[slot_idx] = 1'b0;
                        running_next[slot_idx] = 1'b1;
                    end
                    else
                    begin
                        res_status_next = tpcb_pkg::ST_ERR;
                    end
                end
                tpcb_pkg::OP_STOP:
                begin
                    if (stop_ok)
                    begin
                        running_next[slot_idx] = 1'b0;
                        expired_next[slot_idx] = 1'b0;
                    end
                    else
                    begin
                        res_status_next = tpcb_pkg::ST_ERR;
                    end
                end
                tpcb_pkg::OP_FREE:
                begin
                    if (slot_ok)
                    begin
                        in_use_next[slot_idx]  = 1'b0;
                        running_next[slot_idx] = 1'b0;
                        expired_next[slot_idx] = 1'b0;
                    end
                    else
                    begin
                        res_status_next = tpcb_pkg::ST_ERR;
                    end
                end
                tpcb_pkg::OP_ALLOC, tpcb_pkg::OP_TICK, tpcb_pkg::OP_SERVICE:
                begin
                    res_status_next = tpcb_pkg::ST_OK;
                end
                default:
                begin
                    res_status_next = tpcb_pkg::ST_ERR;
                end
            endcase
        end

        // One slot of an allocate or service scan.
        if (cmd.scan)
        begin
            if (hit)
            begin
                res_slot_next = 3'(idx_reg);
                if (op_reg == tpcb_pkg::OP_ALLOC)
                begin
                    in_use_next[idx_reg]  = 1'b1;
                    running_next[idx_reg] = 1'b0;
                    expired_next[idx_reg] = 1'b0;
                end
                else
                begin
                    expired_next[idx_reg] = 1'b0;
                    res_fire_next         = mode_reg[idx_reg];
                    if (mode_reg[idx_reg])
                    begin
                        running_next[idx_reg] = 1'b0;
                    end
                end
            end
            else
            begin
                idx_next = IDX_W'(idx_reg + 1'b1);
                if (idx_reg == LAST_IDX)
                begin
                    res_status_next = (op_reg == tpcb_pkg::OP_ALLOC) ? tpcb_pkg::ST_ERR
                                                                     : tpcb_pkg::ST_NONE;
                end
            end
        end

        // Sweep issue advances the counter; the stage behind it marks expiry.
        if (cmd.issue)
        begin
            idx_next = IDX_W'(idx_reg + 1'b1);
        end
        if (s1_active && s1_expire)
        begin
            expired_next[s1_idx_reg] = 1'b1;
            res_wake_next            = 1'b1;
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            running_reg   <= '0;
            expired_reg   <= '0;
            mode_reg      <= '0;
            idx_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            running_reg   <= running_next;
            expired_reg   <= expired_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            s1_vld_reg    <= cmd.issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg       <= req_op;
            slot_reg     <= req_slot;
            period_reg   <= req_period;
            one_shot_reg <= req_one_shot;
        end
        s1_idx_reg     <= idx_reg;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_fire_reg   <= res_fire_next;
        res_wake_reg   <= res_wake_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_fire_reg   <= res_fire_reg;
            out_wake_reg   <= res_wake_reg;
        end
    end

    // Count memories: at most one write and one registered read each cycle.
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_wa] <= rem_wd;
        end
        if (start_ok)
        begin
            rel_mem[slot_idx] <= period_reg;
        end
        rem_rd_reg <= rem_mem[idx_reg];
        rel_rd_reg <= rel_mem[idx_reg];
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_result_slot   = out_slot_reg;
    assign rsp_fire_one_shot = out_fire_reg;
    assign rsp_wake          = out_wake_reg;

endmodule
